// ===== hw/rtl/bse_pkg.sv =====
// ============================================================================
// bse_pkg: shared types, codes and helpers for the bouncing sprite engine
// Item layouts, operation and register codes, and saturating arithmetic.
// ============================================================================
package bse_pkg;

    // Operation codes carried in the func field
    localparam logic [2:0] FUNC_WRITE = 3'd0;
    localparam logic [2:0] FUNC_READ  = 3'd1;
    localparam logic [2:0] FUNC_TICK  = 3'd2;
    localparam logic [2:0] FUNC_PLACE = 3'd3;
    localparam logic [2:0] FUNC_STEP  = 3'd4;
    localparam logic [2:0] FUNC_SPEED = 3'd5;

    // Step directions
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_SPRITE_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_SPRITE_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_FRAME_COUNT   = 3'd2;
    localparam logic [2:0] CFG_MARGIN_RIGHT  = 3'd3;
    localparam logic [2:0] CFG_MARGIN_LEFT   = 3'd4;
    localparam logic [2:0] CFG_MARGIN_TOP    = 3'd5;
    localparam logic [2:0] CFG_MARGIN_BOTTOM = 3'd6;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 6;
    localparam int PIXEL_W     = 24;

    typedef struct packed {
        logic [2:0]         func;
        logic [3:0]         frame;
        logic [4:0]         row;
        logic [4:0]         col;
        logic signed [7:0]  pos_x;
        logic signed [7:0]  pos_y;
        logic [23:0]        value;
        logic [1:0]         direction;
        logic [3:0]         speed_x;
        logic [3:0]         speed_y;
        logic [15:0]        step_gap;
    } t_in_item;

    typedef struct packed {
        logic [23:0]        pixel;
        logic               bad_access;
        logic signed [7:0]  left_edge;
        logic signed [7:0]  top_edge;
        logic signed [7:0]  center_col;
        logic signed [7:0]  center_row;
    } t_out_item;

    typedef struct packed {
        logic [4:0]         sprite_width;
        logic [4:0]         sprite_height;
        logic [3:0]         frame_count;
        logic signed [5:0]  margin_right;
        logic signed [5:0]  margin_left;
        logic signed [5:0]  margin_top;
        logic signed [5:0]  margin_bottom;
    } t_cfg;

    // One operation handed to the motion unit
    typedef struct packed {
        logic               en;
        logic [2:0]         func;
        logic [1:0]         direction;
        logic signed [7:0]  pos_x;
        logic signed [7:0]  pos_y;
        logic [3:0]         speed_x;
        logic [3:0]         speed_y;
        logic [15:0]        step_gap;
    } t_motion_cmd;

    // Frame store access strobes
    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

    // Clamp a 10-bit signed value to the 8-bit signed range
    function automatic logic signed [7:0] sat8(input logic signed [9:0] v);
        logic signed [7:0] res;
        if (v > 10'sd127) begin
            res = 8'sd127;
        end else if (v < -10'sd128) begin
            res = -8'sd128;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

    // (2*edge + size - 1) / 2, truncated toward zero, saturated
    function automatic logic signed [7:0] center_of(input logic signed [7:0] edge_pos,
                                                    input logic [4:0] size);
        logic signed [9:0] sum;
        logic signed [9:0] adj;
        logic signed [9:0] half;
        sum  = $signed({edge_pos[7], edge_pos, 1'b0}) + $signed({5'b0, size}) - 10'sd1;
        adj  = sum + ((sum[9] && sum[0]) ? 10'sd1 : 10'sd0);
        half = adj >>> 1;
        return sat8(half);
    endfunction

endpackage

// ===== hw/rtl/bse_in_if.sv =====
// ============================================================================
// bse_in_if: operation channel into the sprite engine
// Valid/ready handshake carrying one operation item per transfer.
// ============================================================================
interface bse_in_if;
    import bse_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/bse_out_if.sv =====
// ============================================================================
// bse_out_if: result channel out of the sprite engine
// Valid/ready handshake carrying one result item per transfer.
// ============================================================================
interface bse_out_if;
    import bse_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/bse_frame_store.sv =====
// ============================================================================
// bse_frame_store: animation frame pixel memory
// Single-port synchronous RAM with registered read, zeroed by a
// sweep after reset.
// ============================================================================
module bse_frame_store #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bse_pkg::t_mem_ctl     i_ctl,
    input  logic [ADDR_W-1:0]     i_addr,
    input  logic [bse_pkg::PIXEL_W-1:0] i_wdata,
    output logic [bse_pkg::PIXEL_W-1:0] o_rdata,
    output logic                  o_clear_done
);
    import bse_pkg::*;

    logic [PIXEL_W-1:0] mem [DEPTH];
    logic [PIXEL_W-1:0] r_rdata;
    logic [ADDR_W-1:0]  r_clr_addr;
    logic               r_clr_done;

    // Clearing sweep, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_clr_done <= 1'b0;
        end else if (!r_clr_done) begin
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_clr_done <= 1'b1;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // Write port: sweep has priority, then user writes
    always_ff @(posedge i_clk) begin
        if (!r_clr_done) begin
            mem[r_clr_addr] <= '0;
        end else if (i_ctl.we) begin
            mem[i_addr] <= i_wdata;
        end
    end

    // Registered read, holds until the next read strobe
    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata      = r_rdata;
    assign o_clear_done = r_clr_done;
endmodule

// ===== hw/rtl/bse_motion.sv =====
// ============================================================================
// bse_motion: sprite position, velocity and tick divider
// Applies tick, place, step and set-speed operations with edge bounce
// and position saturation.
// ============================================================================
module bse_motion #(
    parameter int SCREEN_LAST_COL = 14,
    parameter int SCREEN_LAST_ROW = 9
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bse_pkg::t_cfg         i_cfg,
    input  bse_pkg::t_motion_cmd  i_cmd,
    output logic signed [7:0]     o_left,
    output logic signed [7:0]     o_top
);
    import bse_pkg::*;

    localparam logic signed [9:0] LAST_COL_W = 10'(SCREEN_LAST_COL);
    localparam logic signed [9:0] LAST_ROW_W = 10'(SCREEN_LAST_ROW);

    logic signed [7:0] r_left, n_left;
    logic signed [7:0] r_top,  n_top;
    logic signed [4:0] r_vx,   n_vx;
    logic signed [4:0] r_vy,   n_vy;
    logic [15:0]       r_tick, n_tick;
    logic [15:0]       r_period, n_period;

    logic signed [9:0] left_w, top_w, width_w, height_w;
    logic signed [9:0] mr_w, ml_w, mt_w, mb_w;
    logic [15:0]       tick_inc;
    logic              flip_x, flip_y;
    logic signed [4:0] vx_new, vy_new;

    // Widened operands for the edge compares
    always_comb begin
        left_w   = {{2{r_left[7]}}, r_left};
        top_w    = {{2{r_top[7]}}, r_top};
        width_w  = $signed({5'b0, i_cfg.sprite_width});
        height_w = $signed({5'b0, i_cfg.sprite_height});
        mr_w     = {{4{i_cfg.margin_right[5]}}, i_cfg.margin_right};
        ml_w     = {{4{i_cfg.margin_left[5]}}, i_cfg.margin_left};
        mt_w     = {{4{i_cfg.margin_top[5]}}, i_cfg.margin_top};
        mb_w     = {{4{i_cfg.margin_bottom[5]}}, i_cfg.margin_bottom};
        tick_inc = r_tick + 16'd1;
        flip_x   = (!r_vx[4] && (r_vx != 5'sd0) && (left_w > LAST_COL_W - mr_w)) ||
                   (r_vx[4] && (left_w + width_w - 10'sd1 < ml_w));
        flip_y   = (!r_vy[4] && (r_vy != 5'sd0) && (top_w > LAST_ROW_W - mb_w)) ||
                   (r_vy[4] && (top_w + height_w - 10'sd1 < mt_w));
        vx_new   = flip_x ? -r_vx : r_vx;
        vy_new   = flip_y ? -r_vy : r_vy;
    end

    // Next-state for the selected operation
    always_comb begin
        n_left   = r_left;
        n_top    = r_top;
        n_vx     = r_vx;
        n_vy     = r_vy;
        n_tick   = r_tick;
        n_period = r_period;
        if (i_cmd.en) begin
            unique case (i_cmd.func)
                FUNC_TICK: begin
                    if (tick_inc >= r_period) begin
                        n_vx   = vx_new;
                        n_vy   = vy_new;
                        n_left = sat8(left_w + {{5{vx_new[4]}}, vx_new});
                        n_top  = sat8(top_w + {{5{vy_new[4]}}, vy_new});
                        n_tick = '0;
                    end else begin
                        n_tick = tick_inc;
                    end
                end
                FUNC_PLACE: begin
                    n_left = i_cmd.pos_x;
                    n_top  = i_cmd.pos_y;
                end
                FUNC_STEP: begin
                    unique case (i_cmd.direction)
                        DIR_UP:    n_top  = sat8(top_w - 10'sd1);
                        DIR_DOWN:  n_top  = sat8(top_w + 10'sd1);
                        DIR_LEFT:  n_left = sat8(left_w - 10'sd1);
                        DIR_RIGHT: n_left = sat8(left_w + 10'sd1);
                        default:   n_left = r_left;
                    endcase
                end
                FUNC_SPEED: begin
                    n_vx     = r_vx[4] ? 5'sd0 - $signed({1'b0, i_cmd.speed_x})
                                       : $signed({1'b0, i_cmd.speed_x});
                    n_vy     = r_vy[4] ? 5'sd0 - $signed({1'b0, i_cmd.speed_y})
                                       : $signed({1'b0, i_cmd.speed_y});
                    n_period = i_cmd.step_gap;
                    n_tick   = '0;
                end
                default: begin
                    n_tick = r_tick;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_top    <= '0;
            r_vx     <= '0;
            r_vy     <= '0;
            r_tick   <= '0;
            r_period <= 16'd1;
        end else begin
            r_left   <= n_left;
            r_top    <= n_top;
            r_vx     <= n_vx;
            r_vy     <= n_vy;
            r_tick   <= n_tick;
            r_period <= n_period;
        end
    end

    assign o_left = r_left;
    assign o_top  = r_top;
endmodule

// ===== hw/rtl/bouncing_sprite_engine.sv =====
// Sequence: an item is captured, then executed (the frame store access whose
// registered read data forms the result), then its result is registered; the
// next item can be taken as that result is registered, but not during execute
// or while the result register is stalled.
// Reset: synchronous, active low; afterwards the frame store is zeroed by a
// sweep of all MAX_FRAMES*MAX_ROWS*MAX_COLS entries (2048 by default) with ready low.
// ============================================================================
// bouncing_sprite_engine: sprite engine for a small LED matrix
// Frame pixel store, sprite motion with bounce, and screen pixel readout.
// ============================================================================
module bouncing_sprite_engine #(
    parameter int MAX_FRAMES      = 8,
    parameter int MAX_ROWS        = 16,
    parameter int MAX_COLS        = 16,
    parameter int SCREEN_LAST_COL = 14,
    parameter int SCREEN_LAST_ROW = 9
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    bse_in_if.sink                           i_in,
    bse_out_if.source                        o_out,
    input  logic                             i_cfg_we,
    input  logic [bse_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [bse_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import bse_pkg::*;

    localparam int DEPTH  = MAX_FRAMES * MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]        r_state, n_state;
    t_in_item          r_item;
    t_cfg              r_cfg;
    logic              r_bad;
    logic              r_hit;
    logic              r_out_valid;
    t_out_item         r_out_item;

    logic              clear_done;
    logic              out_free;
    logic              in_xfer;
    logic              wr_ok, rd_ok;
    logic signed [8:0] xx, yy;
    logic [ADDR_W-1:0] wr_addr, rd_addr, mem_addr;
    t_mem_ctl          mem_ctl;
    logic [PIXEL_W-1:0] mem_rdata;
    t_motion_cmd       mcmd;
    logic signed [7:0] left, top;
    t_out_item         result;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SPRITE_WIDTH:  r_cfg.sprite_width  <= i_cfg_data[4:0];
                CFG_SPRITE_HEIGHT: r_cfg.sprite_height <= i_cfg_data[4:0];
                CFG_FRAME_COUNT:   r_cfg.frame_count   <= i_cfg_data[3:0];
                CFG_MARGIN_RIGHT:  r_cfg.margin_right  <= i_cfg_data;
                CFG_MARGIN_LEFT:   r_cfg.margin_left   <= i_cfg_data;
                CFG_MARGIN_TOP:    r_cfg.margin_top    <= i_cfg_data;
                CFG_MARGIN_BOTTOM: r_cfg.margin_bottom <= i_cfg_data;
                default:           r_cfg <= r_cfg;
            endcase
        end
    end

    // Handshake
    assign out_free   = !r_out_valid || o_out.ready;
    assign i_in.ready = clear_done &&
                        ((r_state == S_IDLE) || ((r_state == S_DONE) && out_free));
    assign in_xfer    = i_in.valid && i_in.ready;

    // Address range checks and frame store addressing
    always_comb begin
        xx = $signed({r_item.pos_x[7], r_item.pos_x}) - $signed({left[7], left});
        yy = $signed({r_item.pos_y[7], r_item.pos_y}) - $signed({top[7], top});
        wr_ok = (r_item.frame < r_cfg.frame_count) && (int'(r_item.frame) < MAX_FRAMES) &&
                (r_item.row < r_cfg.sprite_height) && (int'(r_item.row) < MAX_ROWS) &&
                (r_item.col < r_cfg.sprite_width) && (int'(r_item.col) < MAX_COLS);
        rd_ok = !xx[8] && (xx < $signed({4'b0, r_cfg.sprite_width})) &&
                (int'(xx) < MAX_COLS) &&
                !yy[8] && (yy < $signed({4'b0, r_cfg.sprite_height})) &&
                (int'(yy) < MAX_ROWS) &&
                (r_item.frame < r_cfg.frame_count) && (int'(r_item.frame) < MAX_FRAMES);
        wr_addr = ADDR_W'((int'(r_item.frame) * MAX_ROWS + int'(r_item.row)) * MAX_COLS
                          + int'(r_item.col));
        rd_addr = ADDR_W'((int'(r_item.frame) * MAX_ROWS + int'(yy[6:0])) * MAX_COLS
                          + int'(xx[6:0]));
        mem_ctl.we = (r_state == S_EXEC) && (r_item.func == FUNC_WRITE) && wr_ok;
        mem_ctl.re = (r_state == S_EXEC) && (r_item.func == FUNC_READ) && rd_ok;
        mem_addr   = (r_item.func == FUNC_WRITE) ? wr_addr : rd_addr;
    end

    bse_frame_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (mem_ctl),
        .i_addr       (mem_addr),
        .i_wdata      (r_item.value),
        .o_rdata      (mem_rdata),
        .o_clear_done (clear_done)
    );

    // Motion operations run in the execute cycle
    always_comb begin
        mcmd.en        = (r_state == S_EXEC);
        mcmd.func      = r_item.func;
        mcmd.direction = r_item.direction;
        mcmd.pos_x     = r_item.pos_x;
        mcmd.pos_y     = r_item.pos_y;
        mcmd.speed_x   = r_item.speed_x;
        mcmd.speed_y   = r_item.speed_y;
        mcmd.step_gap  = r_item.step_gap;
    end

    bse_motion #(
        .SCREEN_LAST_COL (SCREEN_LAST_COL),
        .SCREEN_LAST_ROW (SCREEN_LAST_ROW)
    ) u_motion (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_cmd   (mcmd),
        .o_left  (left),
        .o_top   (top)
    );

    // Result assembly from updated position and read data
    always_comb begin
        result.pixel      = r_hit ? mem_rdata : '0;
        result.bad_access = r_bad;
        result.left_edge  = left;
        result.top_edge   = top;
        result.center_col = center_of(left, r_cfg.sprite_width);
        result.center_row = center_of(top, r_cfg.sprite_height);
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_xfer) n_state = S_EXEC;
            S_EXEC: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = in_xfer ? S_EXEC : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item <= i_in.payload;
        end
        if (r_state == S_EXEC) begin
            r_bad <= (r_item.func == FUNC_WRITE) && !wr_ok;
            r_hit <= mem_ctl.re;
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out_item <= result;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out_item;
endmodule

// ===== hw/rtl/bse_checker.sv =====
// ============================================================================
// bse_port_checks: port-level checks for the sprite engine
// Handshake stability, sequencing after reset and transfer, result sanity.
// ============================================================================
module bse_port_checks (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  bse_pkg::t_out_item i_out_item
);
    import bse_pkg::*;

    // Result held until transferred
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_item))
        else $error("result changed while stalled");

    // Store sweep keeps input closed right after reset
    a_ready_after_reset: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !i_in_ready)
        else $error("input open during store clear");

    // One operation in flight: no transfer in the cycle after a transfer
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken during execute");

    // A pixel comes only from a read, a flag only from a write
    a_pixel_or_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.bad_access |-> (i_out_item.pixel == '0))
        else $error("pixel and bad access flag together");
endmodule

bind bouncing_sprite_engine bse_port_checks u_bse_port_checks (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_item  (o_out.payload)
);
